// ===== src/assert_macros.svh =====
// Assertion shorthands shared by the RTL files.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/rem_pkg.sv =====
package rem_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int CFG_W = 9;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [1:0] REG_FIND_MAXIMA = 2'd0;
	localparam logic [1:0] REG_IMAGE_WIDTH = 2'd1;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

	localparam logic [1:0] CLS_UNKNOWN = 2'd0;
	localparam logic [1:0] CLS_NON = 2'd1;
	localparam logic [1:0] CLS_SHARP = 2'd2;

	typedef struct packed {
		logic operation;
		logic signed [SAMPLE_BITS-1:0] pixel_value;
	} cmd_t;

	typedef struct packed {
		logic is_extremum;
		logic last_pixel;
	} res_t;

	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} qctl_t;

endpackage

// ===== src/regional_extrema_marker_unit.sv =====
// Regional extremum marker. A load word (operation 0) stores one pixel in raster order;
// busy stays low. A read word (operation 1) returns one mask bit through ST_RD_ISSUE and
// ST_RD_OUT, on result with result_strobe high for one cycle; the receiver cannot
// stall, so it must take the word then. The first read after a load or a register write first
// classifies the whole image and floods plateaus, unless all loaded pixels are equal, all
// through one single-port pixel and class memory. No clearing pass runs after reset.
`include "assert_macros.svh"

module regional_extrema_marker_unit import rem_pkg::*; #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input cmd_t cmd,
	output res_t result,
	output logic result_strobe,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	localparam int TW = AW + 1;
	localparam int XW = $clog2(MAX_WIDTH + 1);
	localparam int YW = $clog2(MAX_HEIGHT + 1);
	localparam int JW = $clog2(MAX_WIDTH);
	localparam int EW = AW + JW;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_RD_ISSUE = 5'd1;
	localparam logic [4:0] ST_RD_OUT = 5'd2;
	localparam logic [4:0] ST_C_V = 5'd3;
	localparam logic [4:0] ST_C_VD = 5'd4;
	localparam logic [4:0] ST_C_NB = 5'd5;
	localparam logic [4:0] ST_C_NBD = 5'd6;
	localparam logic [4:0] ST_C_WR = 5'd7;
	localparam logic [4:0] ST_S_RD = 5'd8;
	localparam logic [4:0] ST_S_RDD = 5'd9;
	localparam logic [4:0] ST_S_NB = 5'd10;
	localparam logic [4:0] ST_S_NBD = 5'd11;
	localparam logic [4:0] ST_S_MARK = 5'd12;
	localparam logic [4:0] ST_F_POP = 5'd13;
	localparam logic [4:0] ST_F_POPD = 5'd14;
	localparam logic [4:0] ST_F_NB = 5'd15;
	localparam logic [4:0] ST_F_NBD = 5'd16;

	localparam logic [1:0] NB_UP = 2'd0;
	localparam logic [1:0] NB_LEFT = 2'd1;
	localparam logic [1:0] NB_RIGHT = 2'd2;
	localparam logic [1:0] NB_DOWN = 2'd3;

	function automatic logic better(input logic fm, input logic signed [SAMPLE_BITS-1:0] a,
			input logic signed [SAMPLE_BITS-1:0] b);
		return fm ? (a > b) : (a < b);
	endfunction

	logic [4:0] state_q;
	logic find_maxima_q;
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [AW-1:0] lpos_q;
	logic [AW-1:0] rpos_q;
	logic computed_q;
	logic signed [SAMPLE_BITS-1:0] lowest_q;
	logic signed [SAMPLE_BITS-1:0] highest_q;

	logic [AW-1:0] k_q;
	logic [JW-1:0] j_q;
	logic [1:0] t_q;
	logic signed [SAMPLE_BITS-1:0] v_q;
	logic any_q;
	logic all_q;

	logic signed [SAMPLE_BITS-1:0] pix_mem [DEPTH];
	logic [1:0] cls_mem [DEPTH];
	logic signed [SAMPLE_BITS-1:0] pix_rd_q;
	logic [1:0] cls_rd_q;

	logic [XW-1:0] eff_w;
	logic [YW-1:0] eff_h;
	logic [XW+YW-1:0] prod;
	logic [TW-1:0] total;
	logic [TW-1:0] w_a;
	logic [AW-1:0] lpos_eff;
	logic [AW-1:0] rpos_eff;
	logic uniform;
	logic load_acc;
	logic read_acc;

	logic nb_valid;
	logic [AW-1:0] nb_addr;
	logic [JW-1:0] nb_j;
	logic last_t;
	logic k_last;
	logic [AW-1:0] k_next;
	logic [JW-1:0] j_next;

	logic [AW-1:0] mem_addr;
	logic pix_we;
	logic cls_we;
	logic [1:0] cls_wdata;
	logic [1:0] cls_new;

	qctl_t qctl;
	logic [EW-1:0] q_wdata;
	logic [EW-1:0] q_rdata;
	logic q_empty;

	always_comb begin
		if (width_q == '0) eff_w = XW'(1);
		else if (32'(width_q) > MAX_WIDTH) eff_w = XW'(MAX_WIDTH);
		else eff_w = XW'(width_q);
		if (height_q == '0) eff_h = YW'(1);
		else if (32'(height_q) > MAX_HEIGHT) eff_h = YW'(MAX_HEIGHT);
		else eff_h = YW'(height_q);
	end

	assign prod = (XW+YW)'(eff_w) * (XW+YW)'(eff_h);
	assign total = TW'(prod);
	assign w_a = TW'(eff_w);
	assign lpos_eff = (TW'(lpos_q) >= total) ? '0 : lpos_q;
	assign rpos_eff = (TW'(rpos_q) >= total) ? '0 : rpos_q;
	assign uniform = (lowest_q == highest_q);
	assign busy = (state_q != ST_IDLE);
	assign load_acc = start && !busy && (cmd.operation == OP_LOAD);
	assign read_acc = start && !busy && (cmd.operation == OP_READ);

	// Neighbor under consideration, selected by t_q.
	always_comb begin
		case (t_q)
			NB_UP: begin
				nb_valid = (TW'(k_q) >= w_a);
				nb_addr = AW'(TW'(k_q) - w_a);
				nb_j = j_q;
			end
			NB_LEFT: begin
				nb_valid = (j_q != '0);
				nb_addr = k_q - 1'b1;
				nb_j = j_q - 1'b1;
			end
			NB_RIGHT: begin
				nb_valid = (TW'(j_q) + 1'b1 < w_a);
				nb_addr = k_q + 1'b1;
				nb_j = j_q + 1'b1;
			end
			default: begin
				nb_valid = (TW'(k_q) + w_a < total);
				nb_addr = AW'(TW'(k_q) + w_a);
				nb_j = j_q;
			end
		endcase
	end

	assign last_t = (t_q == NB_DOWN);
	assign k_last = (TW'(k_q) + 1'b1 == total);
	assign k_next = k_q + 1'b1;
	assign j_next = (TW'(j_q) + 1'b1 == w_a) ? '0 : j_q + 1'b1;
	assign cls_new = any_q ? CLS_NON : (all_q ? CLS_SHARP : CLS_UNKNOWN);

	always_comb begin
		mem_addr = k_q;
		pix_we = 1'b0;
		cls_we = 1'b0;
		cls_wdata = CLS_NON;
		qctl = '0;
		q_wdata = {nb_addr, nb_j};
		unique case (state_q)
			ST_IDLE: begin
				mem_addr = lpos_eff;
				pix_we = load_acc;
				qctl.clear = read_acc;
			end
			ST_RD_ISSUE: mem_addr = rpos_eff;
			ST_C_NB, ST_C_NBD, ST_S_NB, ST_F_NB: mem_addr = nb_addr;
			ST_C_WR: begin
				cls_we = 1'b1;
				cls_wdata = cls_new;
			end
			ST_S_MARK: begin
				cls_we = 1'b1;
				qctl.push = 1'b1;
				q_wdata = {k_q, j_q};
			end
			ST_F_POPD: qctl.pop = 1'b1;
			ST_F_NBD: begin
				mem_addr = nb_addr;
				cls_we = (cls_rd_q == CLS_UNKNOWN);
				qctl.push = (cls_rd_q == CLS_UNKNOWN);
			end
			default: mem_addr = k_q;
		endcase
	end

	// Single port, read before write; no state writes and re-reads one entry in one cycle.
	always_ff @(posedge clk) begin
		if (pix_we) pix_mem[mem_addr] <= cmd.pixel_value;
		if (cls_we) cls_mem[mem_addr] <= cls_wdata;
		pix_rd_q <= pix_mem[mem_addr];
		cls_rd_q <= cls_mem[mem_addr];
	end

	rem_queue #(
		.DEPTH(DEPTH),
		.ENTRY_W(EW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(qctl),
		.wdata(q_wdata),
		.rdata(q_rdata),
		.empty(q_empty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			find_maxima_q <= 1'b1;
			width_q <= CFG_W'(256);
			height_q <= CFG_W'(256);
			lpos_q <= '0;
			rpos_q <= '0;
			computed_q <= 1'b0;
			lowest_q <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			highest_q <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FIND_MAXIMA: begin
						find_maxima_q <= cfg_data[0];
						computed_q <= 1'b0;
						rpos_q <= '0;
					end
					REG_IMAGE_WIDTH: begin
						width_q <= cfg_data;
						computed_q <= 1'b0;
						rpos_q <= '0;
					end
					REG_IMAGE_HEIGHT: begin
						height_q <= cfg_data;
						computed_q <= 1'b0;
						rpos_q <= '0;
					end
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (load_acc) begin
						if (lpos_eff == '0) begin
							lowest_q <= cmd.pixel_value;
							highest_q <= cmd.pixel_value;
						end else begin
							if (cmd.pixel_value < lowest_q) lowest_q <= cmd.pixel_value;
							if (cmd.pixel_value > highest_q) highest_q <= cmd.pixel_value;
						end
						lpos_q <= (TW'(lpos_eff) + 1'b1 >= total) ? '0 : lpos_eff + 1'b1;
						computed_q <= 1'b0;
						rpos_q <= '0;
					end else if (read_acc) begin
						// Every classification pass walks the image from the first pixel.
						k_q <= '0;
						j_q <= '0;
						if (!uniform && !computed_q) state_q <= ST_C_V;
						else state_q <= ST_RD_ISSUE;
					end
				end
				ST_RD_ISSUE: state_q <= ST_RD_OUT;
				ST_RD_OUT: begin
					rpos_q <= (TW'(rpos_eff) + 1'b1 >= total) ? '0 : rpos_eff + 1'b1;
					state_q <= ST_IDLE;
				end
				ST_C_V: state_q <= ST_C_VD;
				ST_C_VD: begin
					v_q <= pix_rd_q;
					t_q <= NB_UP;
					any_q <= 1'b0;
					all_q <= 1'b1;
					state_q <= ST_C_NB;
				end
				ST_C_NB: begin
					if (nb_valid) state_q <= ST_C_NBD;
					else if (last_t) state_q <= ST_C_WR;
					else t_q <= t_q + 1'b1;
				end
				ST_C_NBD: begin
					any_q <= any_q | better(find_maxima_q, pix_rd_q, v_q);
					all_q <= all_q & better(find_maxima_q, v_q, pix_rd_q);
					t_q <= t_q + 1'b1;
					state_q <= last_t ? ST_C_WR : ST_C_NB;
				end
				ST_C_WR: begin
					if (k_last) begin
						k_q <= '0;
						j_q <= '0;
						state_q <= ST_S_RD;
					end else begin
						k_q <= k_next;
						j_q <= j_next;
						state_q <= ST_C_V;
					end
				end
				ST_S_RD: state_q <= ST_S_RDD;
				ST_S_RDD: begin
					if (cls_rd_q != CLS_UNKNOWN) begin
						k_q <= k_next;
						j_q <= j_next;
						state_q <= k_last ? ST_F_POP : ST_S_RD;
					end else begin
						v_q <= pix_rd_q;
						t_q <= NB_UP;
						state_q <= ST_S_NB;
					end
				end
				ST_S_NB: begin
					if (nb_valid) begin
						state_q <= ST_S_NBD;
					end else if (last_t) begin
						k_q <= k_next;
						j_q <= j_next;
						state_q <= k_last ? ST_F_POP : ST_S_RD;
					end else begin
						t_q <= t_q + 1'b1;
					end
				end
				ST_S_NBD: begin
					// An unknown pixel equal to a classified neighbor joins the flood seeds.
					if (cls_rd_q != CLS_UNKNOWN && pix_rd_q == v_q) begin
						state_q <= ST_S_MARK;
					end else if (last_t) begin
						k_q <= k_next;
						j_q <= j_next;
						state_q <= k_last ? ST_F_POP : ST_S_RD;
					end else begin
						t_q <= t_q + 1'b1;
						state_q <= ST_S_NB;
					end
				end
				ST_S_MARK: begin
					k_q <= k_next;
					j_q <= j_next;
					state_q <= k_last ? ST_F_POP : ST_S_RD;
				end
				ST_F_POP: begin
					if (q_empty) begin
						computed_q <= 1'b1;
						state_q <= ST_RD_ISSUE;
					end else begin
						state_q <= ST_F_POPD;
					end
				end
				ST_F_POPD: begin
					k_q <= q_rdata[EW-1:JW];
					j_q <= q_rdata[JW-1:0];
					t_q <= NB_UP;
					state_q <= ST_F_NB;
				end
				ST_F_NB: begin
					if (nb_valid) state_q <= ST_F_NBD;
					else if (last_t) state_q <= ST_F_POP;
					else t_q <= t_q + 1'b1;
				end
				ST_F_NBD: begin
					t_q <= t_q + 1'b1;
					state_q <= last_t ? ST_F_POP : ST_F_NB;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_strobe = (state_q == ST_RD_OUT);
	assign result.is_extremum = !uniform && (cls_rd_q != CLS_NON);
	assign result.last_pixel = (TW'(rpos_eff) + 1'b1 == total);

	`ASSERT_NEXT(a_strobe_gap, result_strobe, !result_strobe, "results on adjacent cycles")
	`ASSERT_NEXT(a_load_one_cycle, load_acc, !busy, "load kept the block busy")
	`ASSERT_NEXT(a_flood_done, state_q == ST_F_POP && q_empty, computed_q, "flood end lost")

endmodule

// ===== src/rem_queue.sv =====
`include "assert_macros.svh"

module rem_queue import rem_pkg::*; #(
	parameter int DEPTH = 65536,
	parameter int ENTRY_W = 24
) (
	input logic clk,
	input logic arst_n,
	input qctl_t ctl,
	input logic [ENTRY_W-1:0] wdata,
	output logic [ENTRY_W-1:0] rdata,
	output logic empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rd_q;
	logic [CW-1:0] head_q;
	logic [CW-1:0] tail_q;
	logic [CW-1:0] count;

	assign count = tail_q - head_q;
	assign empty = (head_q == tail_q);
	assign rdata = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (ctl.clear) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (ctl.push) tail_q <= tail_q + 1'b1;
			if (ctl.pop) head_q <= head_q + 1'b1;
		end
	end

	// The word at the head is always being fetched into rd_q; it is valid in the next cycle.
	always_ff @(posedge clk) begin
		if (ctl.push) mem[tail_q[AW-1:0]] <= wdata;
		rd_q <= mem[head_q[AW-1:0]];
	end

	`ASSERT_IMPL(a_no_overflow, ctl.push && !ctl.clear, count < CW'(DEPTH), "queue overflow")
	`ASSERT_IMPL(a_no_underflow, ctl.pop, !empty, "pop from empty queue")
	`ASSERT_NEXT(a_clear_empties, ctl.clear, empty, "queue not empty after clear")

endmodule
